// ----- rtl/cfi_buffered_program_sequencer_core_macros.svh -----
// Assertion macros for the sequencer RTL.
`ifndef CFI_BUFFERED_PROGRAM_SEQUENCER_CORE_MACROS_SVH
`define CFI_BUFFERED_PROGRAM_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define CFI_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("cfi sequencer: check failed");

`define CFI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("cfi sequencer: check failed");

`else

`define CFI_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)

`define CFI_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- rtl/cfi_bps_pkg.sv -----
// Types and command constants shared by the buffered program sequencer.
`default_nettype none

package cfi_bps_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_DATA   = 2'd1,
        OP_STATUS = 2'd2
    } t_opcode;

    localparam logic [31:0] CMD_BUF_PROGRAM = 32'h0000_00E8;
    localparam logic [31:0] CMD_CONFIRM     = 32'h0000_00D0;
    localparam logic [31:0] CMD_READ_STATUS = 32'h0000_0070;
    localparam logic [31:0] CMD_CLEAR_STAT  = 32'h0000_0050;
    localparam logic [31:0] CMD_READ_ARRAY  = 32'h0000_00FF;
    localparam int          STATUS_READY_BIT = 7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] start_word_offset;
        logic [24:0] word_count;
        logic [31:0] data_word;
        logic [7:0]  status_byte;
    } t_item;

    typedef struct packed {
        logic [23:0] bus_address;
        logic [31:0] bus_data;
        logic        bus_is_read;
        logic        request_done;
        logic        order_error;
    } t_result;

    // all bus accesses caused by one item; last_idx is the count minus one
    typedef struct packed {
        t_result [3:0] res;
        logic [1:0]    last_idx;
    } t_bundle;

endpackage

`default_nettype wire

// ----- rtl/cfi_bps_engine.sv -----
// Sequencer state and the per-item step that builds the bus access bundle.
`default_nettype none

module cfi_bps_engine #(
    parameter int PAGE_WORDS        = 512,
    parameter int ERASE_BLOCK_WORDS = 32768,
    parameter int FLASH_WORDS       = 16777216
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_step,
    input  cfi_bps_pkg::t_item     i_item,
    output cfi_bps_pkg::t_bundle   o_bundle
);
    import cfi_bps_pkg::*;

    localparam int CW = $clog2(PAGE_WORDS + 1);
    localparam logic [23:0] FlashMask = 24'(FLASH_WORDS - 1);
    localparam logic [23:0] PageMask  = 24'(PAGE_WORDS - 1);
    localparam logic [23:0] BlockMask = ~24'(ERASE_BLOCK_WORDS - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DATA,
        PH_POLL
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [23:0]   r_nwa, n_nwa;
    logic [23:0]   r_block, n_block;
    logic [24:0]   r_wr, n_wr;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_size, n_size;

    logic          do_begin, do_finish;
    logic [CW-1:0] chunk_n, room, left_dec;
    logic [23:0]   nwa_inc;

    always_comb begin
        n_phase   = r_phase;
        n_nwa     = r_nwa;
        n_block   = r_block;
        n_wr      = r_wr;
        n_left    = r_left;
        n_size    = r_size;
        do_begin  = 1'b0;
        do_finish = 1'b0;
        chunk_n   = '0;
        room      = CW'(PAGE_WORDS) - CW'(i_item.start_word_offset & PageMask);
        left_dec  = r_left - 1'b1;
        nwa_inc   = (r_nwa + 24'd1) & FlashMask;
        o_bundle  = '0;

        priority if (i_item.opcode == OP_START && r_phase == PH_IDLE) begin
            n_nwa = i_item.start_word_offset & FlashMask;
            n_wr  = i_item.word_count;
            if (i_item.word_count == 25'd0) begin
                do_finish = 1'b1;
            end else begin
                do_begin = 1'b1;
                chunk_n  = (25'(room) > i_item.word_count) ? CW'(i_item.word_count) : room;
            end
        end else if (i_item.opcode == OP_DATA && r_phase == PH_DATA) begin
            o_bundle.res[0].bus_address = r_nwa;
            o_bundle.res[0].bus_data    = i_item.data_word;
            n_nwa  = nwa_inc;
            n_left = left_dec;
            if (left_dec == '0) begin
                // chunk complete: confirm, then first status poll
                o_bundle.res[1].bus_address = r_block;
                o_bundle.res[1].bus_data    = CMD_CONFIRM;
                o_bundle.res[2].bus_address = r_block;
                o_bundle.res[2].bus_data    = CMD_READ_STATUS;
                o_bundle.res[3].bus_address = r_block;
                o_bundle.res[3].bus_is_read = 1'b1;
                o_bundle.last_idx           = 2'd3;
                n_wr    = r_wr - 25'(r_size);
                n_phase = PH_POLL;
            end
        end else if (i_item.opcode == OP_STATUS && r_phase == PH_POLL) begin
            if (!i_item.status_byte[STATUS_READY_BIT]) begin
                o_bundle.res[0].bus_address = r_block;
                o_bundle.res[0].bus_data    = CMD_READ_STATUS;
                o_bundle.res[1].bus_address = r_block;
                o_bundle.res[1].bus_is_read = 1'b1;
                o_bundle.last_idx           = 2'd1;
            end else if (r_wr == 25'd0) begin
                do_finish = 1'b1;
            end else begin
                do_begin = 1'b1;
                chunk_n  = (r_wr >= 25'(PAGE_WORDS)) ? CW'(PAGE_WORDS) : CW'(r_wr);
            end
        end else begin
            o_bundle.res[0].order_error = 1'b1;
        end

        if (do_finish) begin
            o_bundle.res[0].bus_data     = CMD_CLEAR_STAT;
            o_bundle.res[1].bus_address  = n_nwa;
            o_bundle.res[1].bus_data     = CMD_READ_ARRAY;
            o_bundle.res[1].request_done = 1'b1;
            o_bundle.last_idx            = 2'd1;
            n_phase = PH_IDLE;
        end

        if (do_begin) begin
            n_block = n_nwa & BlockMask;
            n_left  = chunk_n;
            n_size  = chunk_n;
            o_bundle.res[0].bus_address = n_block;
            o_bundle.res[0].bus_data    = CMD_BUF_PROGRAM;
            o_bundle.res[1].bus_address = n_block;
            o_bundle.res[1].bus_data    = 32'(chunk_n - 1'b1);
            o_bundle.last_idx           = 2'd1;
            n_phase = PH_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_nwa   <= '0;
            r_block <= '0;
            r_wr    <= '0;
            r_left  <= '0;
            r_size  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_nwa   <= n_nwa;
            r_block <= n_block;
            r_wr    <= n_wr;
            r_left  <= n_left;
            r_size  <= n_size;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cfi_bps_outq.sv -----
// Result register: holds one item's bundle and issues it one beat at a time.
`default_nettype none

module cfi_bps_outq (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  cfi_bps_pkg::t_bundle   i_bundle,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire                    i_taken,
    output cfi_bps_pkg::t_result   o_result,
    output logic                   o_last
);
    import cfi_bps_pkg::*;

    t_bundle    r_bundle;
    logic [1:0] r_idx;
    logic       r_valid;

    assign o_valid  = r_valid;
    assign o_last   = (r_idx == r_bundle.last_idx);
    assign o_result = r_bundle.res[r_idx];
    // free, or its final beat leaves this cycle
    assign o_ready  = !r_valid || (o_last && i_taken);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_taken) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cfi_buffered_program_sequencer_core.sv -----
// Top level of the buffered program sequencer for a 32-bit CFI flash.
// Takes start, data and status beats and emits the flash bus accesses of a
// buffered program: 0xE8 and count minus one per page chunk, the data words, 0xD0,
// then 0x70 and status reads until bit 7 is set, closing with 0x50 and 0xFF. An
// input beat passes an input register and the step logic and lands in a result
// register; the step waits while the result register is busy. Each input beat
// gives one to four output beats; the single output port issues one per
// cycle while the receiver is ready, so a run of data words that each give
// one result streams at one beat per cycle.
// Unexpected beats give a single result flagged order_error and are ignored.
// PAGE_WORDS, ERASE_BLOCK_WORDS and FLASH_WORDS must be powers of two.
`default_nettype none

`include "cfi_buffered_program_sequencer_core_macros.svh"

module cfi_buffered_program_sequencer_core #(
    parameter int PAGE_WORDS        = 512,
    parameter int ERASE_BLOCK_WORDS = 32768,
    parameter int FLASH_WORDS       = 16777216
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // start_word_offset[23:0], word_count[48:24], data_word[80:49],
    // status_byte[88:81], zero pad[95:89]
    input  wire  [95:0] i_s_axis_tdata,
    // opcode[1:0]
    input  wire  [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // bus_address[23:0], bus_data[55:24], zero pad[63:56]
    output logic [63:0] o_m_axis_tdata,
    // bus_is_read[0], request_done[1], order_error[2]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);
    import cfi_bps_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    t_bundle bundle;
    t_result result;
    logic    q_ready;
    logic    step;

    assign step            = r_in_valid && q_ready;
    assign o_s_axis_tready = !r_in_valid || q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.opcode            <= i_s_axis_tuser;
            r_in.start_word_offset <= i_s_axis_tdata[23:0];
            r_in.word_count        <= i_s_axis_tdata[48:24];
            r_in.data_word         <= i_s_axis_tdata[80:49];
            r_in.status_byte       <= i_s_axis_tdata[88:81];
        end
    end

    cfi_bps_engine #(
        .PAGE_WORDS        (PAGE_WORDS),
        .ERASE_BLOCK_WORDS (ERASE_BLOCK_WORDS),
        .FLASH_WORDS       (FLASH_WORDS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_bundle (bundle)
    );

    cfi_bps_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_bundle (bundle),
        .o_ready  (q_ready),
        .o_valid  (o_m_axis_tvalid),
        .i_taken  (i_m_axis_tready),
        .o_result (result),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {8'd0, result.bus_data, result.bus_address};
    assign o_m_axis_tuser = {result.order_error, result.request_done, result.bus_is_read};

    // an accepted beat always sits in the input register next cycle
    `CFI_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_in_valid)
    // an order error is always a lone result
    `CFI_ASSERT_IMPLIES(a_err_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[2], o_m_axis_tlast)
    // the closing write ends its beat's burst
    `CFI_ASSERT_IMPLIES(a_done_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tlast)
    // a status read is always the final access of its burst
    `CFI_ASSERT_IMPLIES(a_read_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tlast)

endmodule

`default_nettype wire
